// File: rtl/lpde_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpde_pkg: shared definitions for the laguerre evaluator
// Microcode word layout, step numbers, the control program and the
// 48-bit saturation helpers.
// ---------------------------------------------------------------------------
package lpde_pkg;

    // value widths
    localparam int VW = 48;
    localparam int LW = 62;
    localparam int CW = 5;
    localparam int PCW = 4;

    // register reset value and hard result cap per abscissa
    localparam logic [CW-1:0] DEGREE_COUNT_RESET = 5'd10;
    localparam int HARD_CAP = 16;

    // one in q16
    localparam logic signed [VW-1:0] Q_ONE = 48'sd65536;

    // saturation limits
    localparam logic signed [VW-1:0] S48_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] S48_MIN = {1'b1, {(VW-1){1'b0}}};

    typedef logic [PCW-1:0] step_t;

    // program step numbers
    localparam step_t STEP_WAIT     = 4'd0;
    localparam step_t STEP_K0       = 4'd1;
    localparam step_t STEP_MUL_LO   = 4'd2;
    localparam step_t STEP_MUL_HI   = 4'd3;
    localparam step_t STEP_ACCUM    = 4'd4;
    localparam step_t STEP_NUM      = 4'd5;
    localparam step_t STEP_DIV_INIT = 4'd6;
    localparam step_t STEP_DIV      = 4'd7;
    localparam step_t STEP_ROUND    = 4'd8;
    localparam step_t STEP_UPDATE   = 4'd9;
    localparam step_t STEP_EMIT     = 4'd10;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_EMIT_ZERO,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_ACCUM,
        OP_NUM,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_ROUND,
        OP_UPDATE,
        OP_EMIT
    } op_t;

    // sequencer branch conditions
    typedef enum logic [2:0] {
        CND_NEXT,
        CND_JUMP,
        CND_WAIT_IN,
        CND_DIV_LOOP,
        CND_EMIT
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    // control program
    function automatic ucode_t ucode_rom(input step_t pc);
        ucode_t w;
        begin
            case (pc)
                STEP_WAIT:     w = '{OP_LOAD,      CND_WAIT_IN,  STEP_WAIT};
                STEP_K0:       w = '{OP_EMIT_ZERO, CND_EMIT,     STEP_MUL_LO};
                STEP_MUL_LO:   w = '{OP_MUL_LO,    CND_NEXT,     STEP_WAIT};
                STEP_MUL_HI:   w = '{OP_MUL_HI,    CND_NEXT,     STEP_WAIT};
                STEP_ACCUM:    w = '{OP_ACCUM,     CND_NEXT,     STEP_WAIT};
                STEP_NUM:      w = '{OP_NUM,       CND_NEXT,     STEP_WAIT};
                STEP_DIV_INIT: w = '{OP_DIV_INIT,  CND_NEXT,     STEP_WAIT};
                STEP_DIV:      w = '{OP_DIV_STEP,  CND_DIV_LOOP, STEP_DIV};
                STEP_ROUND:    w = '{OP_ROUND,     CND_NEXT,     STEP_WAIT};
                STEP_UPDATE:   w = '{OP_UPDATE,    CND_NEXT,     STEP_WAIT};
                STEP_EMIT:     w = '{OP_EMIT,      CND_EMIT,     STEP_MUL_LO};
                default:       w = '{OP_NOP,       CND_JUMP,     STEP_WAIT};
            endcase
            return w;
        end
    endfunction

    // true when a wide value does not fit 48 bits
    function automatic logic sat_clip(input logic signed [LW-1:0] v);
        begin
            return !((&v[LW-1:VW-1]) || !(|v[LW-1:VW-1]));
        end
    endfunction

    // wide value clipped to the 48-bit range
    function automatic logic signed [VW-1:0] sat_value(input logic signed [LW-1:0] v);
        begin
            if (sat_clip(v))
            begin
                return v[LW-1] ? S48_MIN : S48_MAX;
            end
            return v[VW-1:0];
        end
    endfunction

endpackage

// File: rtl/laguerre_poly_deriv_eval_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// laguerre_poly_deriv_eval_core: laguerre polynomial and derivative evaluator
// Microcoded sequencer over a shared 26x25 multiplier and an 8-bit-per-step
// divider; emits L_k(x) and three derivatives for k = 0 .. n-1 per abscissa.
// ---------------------------------------------------------------------------
// degree 0 result is registered from step K0, which follows the taken request
// each further degree runs two multiplier passes for the 74-bit
//   product, three setup steps, eight radix-256 divide steps, round, update, emit
// an abscissa occupies the core until its last degree is emitted, plus stalls
// on m_tready; the next request is taken once the last result is registered
// reset: asynchronous active low, degree_count returns to 10, core idles

module laguerre_poly_deriv_eval_core #(
    parameter int MAX_DEGREES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // configuration write: degree_count
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [4:0]   cfg_data,
    // input stream: [23:0] x_value
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,
    // result stream: [3:0] degree, [51:4] poly_value, [99:52] first_deriv,
    // [147:100] second_deriv, [195:148] third_deriv, [199:196] zero
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,
    // result flags: [0] saturated
    output logic [0:0]   m_tuser,
    output logic         m_tlast
);

    localparam int XW   = 24;
    localparam int VW   = lpde_pkg::VW;
    localparam int LW   = lpde_pkg::LW;
    localparam int KW   = 4;
    localparam int AW   = 26;
    localparam int BW   = 25;
    localparam int PW   = AW + BW;
    localparam int ACCW = 74;
    localparam int KLW  = VW + KW + 1;
    localparam int NUMW = 60;
    localparam int DVW  = 64;
    localparam int DSTEP = 8;
    localparam int DCW  = 3;
    localparam int DEG_CAP = (MAX_DEGREES < lpde_pkg::HARD_CAP) ? MAX_DEGREES
                                                                : lpde_pkg::HARD_CAP;

    // control state
    lpde_pkg::step_t  pc_reg, pc_next;
    logic [4:0]       degree_count_reg;
    logic             m_tvalid_reg;
    logic             sticky_reg, sticky_next;
    logic [KW-1:0]    k_reg;
    logic [KW-1:0]    last_k_reg;
    logic [DCW-1:0]   div_cnt_reg;

    // datapath registers
    logic signed [XW-1:0]   x_reg;
    logic signed [VW-1:0]   lp_reg;
    logic signed [VW-1:0]   lpp_reg;
    logic signed [VW-1:0]   d1_reg, d2_reg, d3_reg;
    logic signed [VW-1:0]   l_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [KLW-1:0]  kl_reg;
    logic signed [NUMW-1:0] num_reg;
    logic [DVW-1:0]         dvd_reg, dvd_next;
    logic [KW-1:0]          rem_reg, rem_next;
    logic                   neg_reg;
    logic signed [LW-1:0]   lw_reg;

    // output register
    logic [KW-1:0]        out_deg_reg;
    logic signed [VW-1:0] out_poly_reg, out_d1_reg, out_d2_reg, out_d3_reg;
    logic                 out_sat_reg, out_last_reg;

    // combinational helpers
    lpde_pkg::ucode_t     ctrl;
    logic                 load_fire, out_free, emit_fire, is_last;
    logic [KW-1:0]        last_k_next;
    logic [4:0]           two_km1;
    logic signed [AW-1:0] a_val;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] prod_next;
    logic signed [KLW-1:0] kl_next;
    logic [NUMW-1:0]      num_mag;
    logic [NUMW:0]        round_mag;
    logic                 round_inc;
    logic signed [LW-1:0] e1, e2, e3;

    assign ctrl = lpde_pkg::ucode_rom(pc_reg);

    // handshakes
    assign cfg_ready = 1'b1;
    assign s_tready  = (ctrl.op == lpde_pkg::OP_LOAD);
    assign load_fire = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_fire = ((ctrl.op == lpde_pkg::OP_EMIT_ZERO) ||
                        (ctrl.op == lpde_pkg::OP_EMIT)) && out_free;
    assign is_last   = (k_reg == last_k_reg);

    // effective degree count, minus one
    always_comb
    begin
        if (degree_count_reg == '0)
        begin
            last_k_next = '0;
        end
        else if (int'(degree_count_reg) > DEG_CAP)
        begin
            last_k_next = KW'(DEG_CAP - 1);
        end
        else
        begin
            last_k_next = KW'(degree_count_reg - 5'd1);
        end
    end

    // sequencer next step
    always_comb
    begin
        case (ctrl.cond)
            lpde_pkg::CND_NEXT:     pc_next = pc_reg + 4'd1;
            lpde_pkg::CND_JUMP:     pc_next = ctrl.target;
            lpde_pkg::CND_WAIT_IN:  pc_next = s_tvalid ? pc_reg + 4'd1 : pc_reg;
            lpde_pkg::CND_DIV_LOOP: pc_next = (div_cnt_reg != '1) ? ctrl.target
                                                                   : pc_reg + 4'd1;
            lpde_pkg::CND_EMIT:
            begin
                if (!out_free)
                begin
                    pc_next = pc_reg;
                end
                else if (is_last)
                begin
                    pc_next = lpde_pkg::STEP_WAIT;
                end
                else
                begin
                    pc_next = ctrl.target;
                end
            end
            default:                pc_next = lpde_pkg::STEP_WAIT;
        endcase
    end

    // recurrence coefficient a = (2k-1) - x in q16
    assign two_km1 = {k_reg, 1'b0} - 5'd1;
    assign a_val   = $signed({5'b0, two_km1, 16'h0000}) - AW'(x_reg);

    // shared multiplier, low or high half of L_{k-1}
    assign mul_b     = (ctrl.op == lpde_pkg::OP_MUL_LO) ? $signed({1'b0, lp_reg[23:0]})
                                                        : BW'($signed(lp_reg[VW-1:24]));
    assign prod_next = a_val * mul_b;

    // (k-1) * L_{k-2}
    assign kl_next = $signed({1'b0, k_reg - 4'd1}) * lpp_reg;

    // numerator magnitude for the divider
    assign num_mag = num_reg[NUMW-1] ? NUMW'(-num_reg) : NUMW'(num_reg);

    // eight quotient bits per step, restoring
    always_comb
    begin
        logic [KW:0] r5;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        for (int i = 0; i < DSTEP; i++)
        begin
            r5 = {rem_next, dvd_next[DVW-1]};
            dvd_next = {dvd_next[DVW-2:0], 1'b0};
            if (r5 >= {1'b0, k_reg})
            begin
                r5 = r5 - {1'b0, k_reg};
                dvd_next[0] = 1'b1;
            end
            rem_next = r5[KW-1:0];
        end
    end

    // round to nearest, ties away from zero
    assign round_inc = ({rem_reg, 1'b0} >= {1'b0, k_reg});
    assign round_mag = dvd_reg[NUMW:0] + {{NUMW{1'b0}}, round_inc};

    // derivative differences
    assign e1 = LW'(d1_reg) - LW'(lp_reg);
    assign e2 = LW'(d2_reg) - LW'(d1_reg);
    assign e3 = LW'(d3_reg) - LW'(d2_reg);

    always_comb
    begin
        sticky_next = sticky_reg;
        if (load_fire)
        begin
            sticky_next = 1'b0;
        end
        else if (ctrl.op == lpde_pkg::OP_UPDATE)
        begin
            sticky_next = sticky_reg || lpde_pkg::sat_clip(lw_reg) ||
                          lpde_pkg::sat_clip(e1) || lpde_pkg::sat_clip(e2) ||
                          lpde_pkg::sat_clip(e3);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= lpde_pkg::STEP_WAIT;
            degree_count_reg <= lpde_pkg::DEGREE_COUNT_RESET;
            m_tvalid_reg     <= 1'b0;
            sticky_reg       <= 1'b0;
            k_reg            <= '0;
            last_k_reg       <= '0;
            div_cnt_reg      <= '0;
        end
        else
        begin
            pc_reg     <= pc_next;
            sticky_reg <= sticky_next;
            if (cfg_valid && cfg_ready)
            begin
                degree_count_reg <= cfg_data;
            end
            if (emit_fire)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (load_fire)
            begin
                k_reg      <= '0;
                last_k_reg <= last_k_next;
            end
            else if (emit_fire)
            begin
                k_reg <= k_reg + 4'd1;
            end
            if (ctrl.op == lpde_pkg::OP_DIV_INIT)
            begin
                div_cnt_reg <= '0;
            end
            else if (ctrl.op == lpde_pkg::OP_DIV_STEP)
            begin
                div_cnt_reg <= div_cnt_reg + 3'd1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            lpde_pkg::OP_LOAD:
            begin
                if (load_fire)
                begin
                    x_reg   <= s_tdata[XW-1:0];
                    lp_reg  <= '0;
                    lpp_reg <= '0;
                    d1_reg  <= '0;
                    d2_reg  <= '0;
                    d3_reg  <= '0;
                end
            end
            lpde_pkg::OP_EMIT_ZERO:
            begin
                if (out_free)
                begin
                    lpp_reg <= lp_reg;
                    lp_reg  <= lpde_pkg::Q_ONE;
                end
            end
            lpde_pkg::OP_MUL_LO:
            begin
                prod_reg <= prod_next;
            end
            lpde_pkg::OP_MUL_HI:
            begin
                acc_reg  <= ACCW'(prod_reg);
                prod_reg <= prod_next;
            end
            lpde_pkg::OP_ACCUM:
            begin
                acc_reg <= acc_reg + (ACCW'(prod_reg) <<< 24);
                kl_reg  <= kl_next;
            end
            lpde_pkg::OP_NUM:
            begin
                num_reg <= NUMW'(acc_reg >>> 16) - NUMW'(kl_reg);
            end
            lpde_pkg::OP_DIV_INIT:
            begin
                dvd_reg <= {{(DVW-NUMW){1'b0}}, num_mag};
                rem_reg <= '0;
                neg_reg <= num_reg[NUMW-1];
            end
            lpde_pkg::OP_DIV_STEP:
            begin
                dvd_reg <= dvd_next;
                rem_reg <= rem_next;
            end
            lpde_pkg::OP_ROUND:
            begin
                lw_reg <= neg_reg ? -$signed({1'b0, round_mag}) : $signed({1'b0, round_mag});
            end
            lpde_pkg::OP_UPDATE:
            begin
                l_reg  <= lpde_pkg::sat_value(lw_reg);
                d1_reg <= lpde_pkg::sat_value(e1);
                d2_reg <= lpde_pkg::sat_value(e2);
                d3_reg <= lpde_pkg::sat_value(e3);
            end
            lpde_pkg::OP_EMIT:
            begin
                if (out_free)
                begin
                    lpp_reg <= lp_reg;
                    lp_reg  <= l_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_deg_reg  <= k_reg;
            out_sat_reg  <= sticky_reg;
            out_last_reg <= is_last;
            if (ctrl.op == lpde_pkg::OP_EMIT_ZERO)
            begin
                out_poly_reg <= lpde_pkg::Q_ONE;
                out_d1_reg   <= '0;
                out_d2_reg   <= '0;
                out_d3_reg   <= '0;
            end
            else
            begin
                out_poly_reg <= l_reg;
                out_d1_reg   <= d1_reg;
                out_d2_reg   <= d2_reg;
                out_d3_reg   <= d3_reg;
            end
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {4'b0000, out_d3_reg, out_d2_reg, out_d1_reg, out_poly_reg, out_deg_reg};
    assign m_tuser[0] = out_sat_reg;
    assign m_tlast    = out_last_reg;

    // a taken request starts the degree-zero step
    assert property (@(posedge clk) disable iff (!rst_n)
        load_fire |=> (pc_reg == lpde_pkg::STEP_K0))
        else $error("sequencer did not start after a request");

    // degree counter stays within the run
    assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg != lpde_pkg::STEP_WAIT) |-> (k_reg <= last_k_reg))
        else $error("degree counter ran past the last degree");

    // clip flag holds for the rest of the abscissa
    assert property (@(posedge clk) disable iff (!rst_n)
        (sticky_reg && !load_fire) |=> sticky_reg)
        else $error("saturation flag dropped inside a run");

    // divider remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == lpde_pkg::STEP_ROUND) |-> (rem_reg < k_reg))
        else $error("divider remainder not below degree");

endmodule
